// ===== sv/vtd_pkg.sv =====
package vtd_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int REF_BITS    = 16;
  localparam int FIELD_BITS  = 16;
  localparam int VIDX_BITS   = 12;
  localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS    = IDX_BITS + 1;
  localparam int ENTRY_BITS  = 3 * REF_BITS;

  typedef logic [REF_BITS-1:0]   ref_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [ENTRY_BITS-1:0] entry_t;

  typedef struct packed {
    logic   rd_en;
    idx_t   rd_addr;
    logic   wr_en;
    idx_t   wr_addr;
    entry_t wr_data;
  } tbl_req_t;

  function automatic ref_t to_zero_based(logic [FIELD_BITS-1:0] one_based);
    logic [31:0] wide;
    wide = 32'(one_based) - 32'd1;
    return wide[REF_BITS-1:0];
  endfunction

  function automatic logic [VIDX_BITS-1:0] to_vertex_index(idx_t idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[VIDX_BITS-1:0];
  endfunction

endpackage

// ===== sv/vtd_if.sv =====
interface vtd_corner_if;
  import vtd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] position_ref;
  logic [FIELD_BITS-1:0] texcoord_ref;
  logic [FIELD_BITS-1:0] normal_ref;

  modport source (output valid, position_ref, texcoord_ref, normal_ref, input ready);
  modport sink (input valid, position_ref, texcoord_ref, normal_ref, output ready);
endinterface

interface vtd_result_if;
  import vtd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [VIDX_BITS-1:0] vertex_index;
  logic                 is_new;
  logic                 table_full;

  modport source (output valid, vertex_index, is_new, table_full, input ready);
  modport sink (input valid, vertex_index, is_new, table_full, output ready);
endinterface

// ===== sv/vtd_table.sv =====
module vtd_table
  import vtd_pkg::*;
(
  input  logic     clk,
  input  tbl_req_t req,
  output entry_t   rd_data
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== sv/vtd_ctrl.sv =====
module vtd_ctrl
  import vtd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  vtd_corner_if.sink          corner,
  vtd_result_if.source        result,
  output tbl_req_t            tbl_req,
  input  entry_t              tbl_rd_data
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_OUT    = 3'b100
  } state_t;

  state_t               state;
  entry_t               key;
  cnt_t                 rd_cnt;
  logic                 pend;
  idx_t                 pend_idx;
  cnt_t                 count;
  logic [VIDX_BITS-1:0] vertex_index;
  logic                 is_new;
  logic                 table_full;

  logic issue;
  logic hit;
  logic exhausted;
  logic full;

  assign issue     = (state == ST_SEARCH) && (rd_cnt < count);
  assign hit       = (state == ST_SEARCH) && pend && (tbl_rd_data == key);
  assign exhausted = (state == ST_SEARCH) && !issue && !pend;
  assign full      = (count == CNT_BITS'(TABLE_DEPTH));

  assign corner.ready        = (state == ST_IDLE);
  assign result.valid        = (state == ST_OUT);
  assign result.vertex_index = vertex_index;
  assign result.is_new       = is_new;
  assign result.table_full   = table_full;

  always_comb begin
    tbl_req.rd_en   = issue;
    tbl_req.rd_addr = rd_cnt[IDX_BITS-1:0];
    tbl_req.wr_en   = exhausted && !hit && !full;
    tbl_req.wr_addr = count[IDX_BITS-1:0];
    tbl_req.wr_data = key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (corner.valid) begin
            key    <= {to_zero_based(corner.position_ref),
                       to_zero_based(corner.texcoord_ref),
                       to_zero_based(corner.normal_ref)};
            rd_cnt <= '0;
            pend   <= 1'b0;
            state  <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          pend     <= issue;
          pend_idx <= rd_cnt[IDX_BITS-1:0];
          if (issue) begin
            rd_cnt <= rd_cnt + CNT_BITS'(1);
          end
          if (hit) begin
            vertex_index <= to_vertex_index(pend_idx);
            is_new       <= 1'b0;
            table_full   <= 1'b0;
            state        <= ST_OUT;
          end else if (exhausted) begin
            if (full) begin
              vertex_index <= '0;
              is_new       <= 1'b0;
              table_full   <= 1'b1;
            end else begin
              vertex_index <= to_vertex_index(count[IDX_BITS-1:0]);
              is_new       <= 1'b1;
              table_full   <= 1'b0;
              count        <= count + CNT_BITS'(1);
            end
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (result.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/vertex_tuple_dedup.sv =====
// Channel  Role    Carries
// corner   sink    position_ref, texcoord_ref, normal_ref (one-based)
// result   source  vertex_index, is_new, table_full
//
// After a request is accepted, the single read port of the triple table and the one comparator
// visit the stored triples in order, one stored triple a cycle, until a match or the last entry.
// A result taken at once lets the next request in on the following cycle.
// Reset empties the table at once by clearing the entry count; there is no clearing pass.
// The block takes one request at a time and holds corner.ready low until the result is taken.
module vertex_tuple_dedup
  import vtd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  vtd_corner_if.sink    corner,
  vtd_result_if.source  result
);

  tbl_req_t tbl_req;
  entry_t   tbl_rd_data;

  vtd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .corner      (corner),
    .result      (result),
    .tbl_req     (tbl_req),
    .tbl_rd_data (tbl_rd_data)
  );

  vtd_table u_table (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (tbl_rd_data)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(result.valid && corner.ready))
    else $error("result pending while a new request is accepted");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (corner.valid && corner.ready) |=> !result.valid)
    else $error("result valid in the cycle after acceptance");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.is_new && result.table_full))
    else $error("is_new and table_full both set");

  a_full_index_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.table_full) |-> (result.vertex_index == '0))
    else $error("table_full with non-zero vertex_index");

endmodule

// ===== verif/vtd_checker.sv =====
module vtd_checker
  import vtd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  vtd_corner_if corner,
  vtd_result_if result,
  output int    errors,
  output int    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VIDX_BITS-1:0] vertex_index;
    logic                 is_new;
    logic                 table_full;
  } vertex_result_t;

  // Each distinct zero-based triple maps to the slot where it was first stored.
  cnt_t           first_slot [entry_t];
  cnt_t           stored_count;
  vertex_result_t expected_vertices[$];

  initial begin
    errors       = 0;
    outstanding  = 0;
    stored_count = '0;
  end

  task automatic report_mismatch(input string what);
    $display("dedup check at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic vertex_result_t dedup_corner(input ref_t p, input ref_t t, input ref_t n);
    entry_t         key;
    vertex_result_t res;
    key = {p, t, n};
    res = '0;
    if (first_slot.exists(key)) begin
      res.vertex_index = VIDX_BITS'(first_slot[key]);
    end else if (stored_count >= TABLE_DEPTH) begin
      res.table_full = 1'b1;
    end else begin
      first_slot[key]  = stored_count;
      res.vertex_index = VIDX_BITS'(stored_count);
      res.is_new       = 1'b1;
      stored_count++;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    vertex_result_t got;
    vertex_result_t want;
    if (rst) begin
      first_slot.delete();
      expected_vertices.delete();
      stored_count = '0;
    end else begin
      // A result taken at this edge always belongs to an earlier request.
      if (result.valid && result.ready) begin
        got = '{result.vertex_index, result.is_new, result.table_full};
        if (expected_vertices.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting, vertex_index %0d",
                                    got.vertex_index));
        end else begin
          want = expected_vertices.pop_front();
          if (got.vertex_index !== want.vertex_index) begin
            report_mismatch($sformatf("vertex_index got %0d, wanted %0d",
                                      got.vertex_index, want.vertex_index));
          end
          if (got.is_new !== want.is_new) begin
            report_mismatch($sformatf("is_new got %b, wanted %b", got.is_new, want.is_new));
          end
          if (got.table_full !== want.table_full) begin
            report_mismatch($sformatf("table_full got %b, wanted %b",
                                      got.table_full, want.table_full));
          end
        end
      end
      if (corner.valid && corner.ready) begin
        want = dedup_corner(ref_t'(corner.position_ref - 1),
                            ref_t'(corner.texcoord_ref - 1),
                            ref_t'(corner.normal_ref - 1));
        expected_vertices = {expected_vertices, want};
      end
    end
    outstanding = expected_vertices.size();
  end

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vtd_pkg::*;

  localparam longint CYCLE_LIMIT   = 40_000_000;
  localparam int     HOLD_CYCLES   = 600;
  localparam int     SETTLE_CYCLES = TABLE_DEPTH + 8;

  typedef enum {
    TRAFFIC_STEADY,
    TRAFFIC_SENDER_IDLE,
    TRAFFIC_RECEIVER_STALL,
    TRAFFIC_BOTH
  } traffic_e;

  typedef struct {
    logic [FIELD_BITS-1:0] pos;
    logic [FIELD_BITS-1:0] tex;
    logic [FIELD_BITS-1:0] nrm;
  } corner_t;

  logic     clk = 1'b0;
  logic     rst;
  int       errors;
  int       outstanding;
  traffic_e traffic = TRAFFIC_STEADY;
  bit       hold_start = 1'b0;
  bit       hold_done = 1'b0;
  longint   cycles = 0;
  corner_t  sent_corners[$];

  vtd_corner_if corner ();
  vtd_result_if result ();

  vertex_tuple_dedup dut (
    .clk    (clk),
    .rst    (rst),
    .corner (corner),
    .result (result)
  );

  vtd_checker dedup_check (
    .clk         (clk),
    .rst         (rst),
    .corner      (corner),
    .result      (result),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic bit sender_idles();
    case (traffic)
      TRAFFIC_SENDER_IDLE: return $urandom_range(99) < 64;
      TRAFFIC_BOTH:        return $urandom_range(99) < 18;
      default:             return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (traffic)
      TRAFFIC_RECEIVER_STALL: return $urandom_range(99) < 64;
      TRAFFIC_BOTH:           return $urandom_range(99) < 18;
      default:                return 1'b0;
    endcase
  endfunction

  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      result.ready = !(hold_start && !hold_done) && !receiver_stalls();
    end
  end

  // The long hold-off keeps results back while requests keep coming, so the block stalls.
  initial begin
    wait (hold_start);
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_done = 1'b1;
  end

  task automatic send_corner(input logic [FIELD_BITS-1:0] p,
                             input logic [FIELD_BITS-1:0] t,
                             input logic [FIELD_BITS-1:0] n);
    corner_t sent;
    while (sender_idles()) begin
      corner.valid        = 1'b0;
      corner.position_ref = FIELD_BITS'($urandom);
      corner.texcoord_ref = FIELD_BITS'($urandom);
      corner.normal_ref   = FIELD_BITS'($urandom);
      @(negedge clk);
    end
    corner.position_ref = p;
    corner.texcoord_ref = t;
    corner.normal_ref   = n;
    corner.valid        = 1'b1;
    @(posedge clk);
    while (!corner.ready) @(posedge clk);
    @(negedge clk);
    sent = '{p, t, n};
    sent_corners = {sent_corners, sent};
  endtask

  task automatic send_random_corner();
    int unsigned pick;
    corner_t     c;
    pick = $urandom_range(99);
    if (pick < 45 && sent_corners.size() > 0) begin
      c = sent_corners[$urandom_range(sent_corners.size() - 1)];
    end else if (pick < 75) begin
      c = '{FIELD_BITS'($urandom_range(8)), FIELD_BITS'($urandom_range(8)),
            FIELD_BITS'($urandom_range(8))};
    end else begin
      c = '{FIELD_BITS'($urandom), FIELD_BITS'($urandom), FIELD_BITS'($urandom)};
    end
    send_corner(c.pos, c.tex, c.nrm);
  endtask

  initial begin
    int k;
    corner.valid        = 1'b0;
    corner.position_ref = '0;
    corner.texcoord_ref = '0;
    corner.normal_ref   = '0;
    rst = 1'b1;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    send_corner(16'd1, 16'd1, 16'd1);
    send_corner(16'd1, 16'd1, 16'd1);
    send_corner(16'd0, 16'd0, 16'd0);
    send_corner('1, '1, '1);
    send_corner(16'd0, 16'd0, 16'd0);
    send_corner(16'd1, 16'd1, 16'd2);
    send_corner(16'd2, 16'd1, 16'd1);
    send_corner(16'd1, 16'd2, 16'd1);
    send_corner(16'd0, '1, 16'd1);
    send_corner(16'd1, 16'd0, '1);
    send_corner(16'h8000, 16'h7FFF, 16'hAAAA);
    send_corner(16'h5555, 16'h8000, 16'h7FFF);
    send_corner(16'd2, 16'd1, 16'd1);
    send_corner('1, '1, '1);
    send_corner(16'd1, 16'd1, 16'd1);

    for (k = 0; k < 4; k++) begin
      traffic = traffic_e'(k);
      repeat (25) send_random_corner();
    end

    traffic    = TRAFFIC_STEADY;
    hold_start = 1'b1;
    repeat (12) send_random_corner();
    wait (hold_done);

    traffic = TRAFFIC_BOTH;
    send_corner(16'd1, 16'd1, 16'd1);
    send_corner(16'd3801, 16'hA5A5, FIELD_BITS'(~3800));
    send_corner(16'd4096, 16'hA5A5, FIELD_BITS'(~4095));
    send_corner(16'h1234, 16'h5678, 16'h9ABC);
    send_corner(16'd0, 16'd0, 16'd0);
    repeat (8) send_random_corner();

    corner.valid = 1'b0;
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
